// ===== rtl/lclip_pkg.sv =====
package lclip_pkg;

  // Field widths
  localparam int CoordBits  = 24;
  localparam int ScreenBits = 12;

  // Derived widths
  localparam int DeltaBits = CoordBits + 1;          // end - start, signed
  localparam int MagBits   = CoordBits;              // |end - start| and clamped numerators
  localparam int RawBits   = CoordBits + 2;          // unclamped edge numerators, signed
  localparam int ProdBits  = 2 * MagBits;            // ratio cross products
  localparam int AccBits   = ScreenBits + MagBits + 1; // point numerator, exact modulo 2^AccBits
  localparam int QuoBits   = ScreenBits;

  // Divider: quotient bits resolved per pipeline stage
  localparam int DivBitsPerStage = 2;
  localparam int DivStages       = (QuoBits + DivBitsPerStage - 1) / DivBitsPerStage;

  localparam int NumPts = 4;  // start x, start y, end x, end y

  // Configuration register indexes
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegScreenWidth  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] RegScreenHeight = CfgIdxBits'(1);

  localparam logic [ScreenBits-1:0] ScreenWidthRst  = ScreenBits'(320);
  localparam logic [ScreenBits-1:0] ScreenHeightRst = ScreenBits'(240);

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [DeltaBits-1:0] delta_t;
  typedef logic signed [RawBits-1:0]   raw_t;
  typedef logic        [MagBits-1:0]   mag_t;
  typedef logic        [ProdBits-1:0]  prod_t;
  typedef logic        [AccBits-1:0]   acc_t;
  typedef logic signed [AccBits-1:0]   sacc_t;
  typedef logic        [QuoBits-1:0]   quo_t;
  typedef logic        [ScreenBits-1:0] screen_t;

  // One axis reduced to an entering and a leaving ratio over a common denominator
  typedef struct packed {
    mag_t den;
    mag_t en;
    mag_t ln;
    logic rej;
  } axis_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } s0_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    delta_t dx;
    delta_t dy;
    axis_t  ax;
    axis_t  ay;
    logic   rej;
  } s1_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    delta_t dx;
    delta_t dy;
    axis_t  ax;
    axis_t  ay;
    prod_t  pex;
    prod_t  pey;
    prod_t  plx;
    prod_t  ply;
    logic   rej;
  } s2_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    delta_t dx;
    delta_t dy;
    mag_t   n0;
    mag_t   d0;
    mag_t   n1;
    mag_t   d1;
    logic   rej;
  } s3_t;

  typedef struct packed {
    prod_t                  c01;
    prod_t                  c10;
    acc_t [NumPts-1:0]      ta;
    acc_t [NumPts-1:0]      tb;
    mag_t                   d0;
    mag_t                   d1;
    logic                   rej;
  } s4_t;

  typedef struct packed {
    acc_t [NumPts-1:0] rem;
    quo_t [NumPts-1:0] quo;
    mag_t              d0;
    mag_t              d1;
    logic              rej;
  } div_t;

endpackage

// ===== rtl/line_clip_to_viewport.sv =====
// Throughput: one segment per cycle; the pipeline advances as a whole and holds
// every stage while a finished result is stalled at the output.
// The clipped points come from a 6-stage restoring divider, 2 quotient bits per stage.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets the rectangle
// to 320 x 240; no clearing pass, the first item is taken right after reset.
module line_clip_to_viewport (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lclip_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [lclip_pkg::ScreenBits-1:0]     cfg_data_i,
  // segment input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [lclip_pkg::CoordBits-1:0] start_x_i,
  input  logic signed [lclip_pkg::CoordBits-1:0] start_y_i,
  input  logic signed [lclip_pkg::CoordBits-1:0] end_x_i,
  input  logic signed [lclip_pkg::CoordBits-1:0] end_y_i,
  // clipped result
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 visible_o,
  output logic [lclip_pkg::ScreenBits-1:0]     out_start_x_o,
  output logic [lclip_pkg::ScreenBits-1:0]     out_start_y_o,
  output logic [lclip_pkg::ScreenBits-1:0]     out_end_x_o,
  output logic [lclip_pkg::ScreenBits-1:0]     out_end_y_o
);

  localparam int DivStages = lclip_pkg::DivStages;
  localparam int NumPts    = lclip_pkg::NumPts;

  // Entering/leaving ratios of one axis; a parallel axis becomes 0/1 and 1/1
  function automatic lclip_pkg::axis_t axis_setup(input lclip_pkg::coord_t  p0,
                                                 input lclip_pkg::delta_t  d,
                                                 input lclip_pkg::screen_t lim);
    lclip_pkg::axis_t r;
    lclip_pkg::raw_t  q_lo;
    lclip_pkg::raw_t  q_hi;
    lclip_pkg::raw_t  en_raw;
    lclip_pkg::raw_t  ln_raw;
    lclip_pkg::raw_t  den_s;
    q_lo = lclip_pkg::raw_t'(p0);
    q_hi = signed'(lclip_pkg::RawBits'(lim)) - lclip_pkg::raw_t'(p0);
    if (d == '0) begin
      r.den = lclip_pkg::MagBits'(1);
      r.en  = '0;
      r.ln  = lclip_pkg::MagBits'(1);
      r.rej = (q_lo < 0) || (q_hi < 0);
    end else begin
      if (d > 0) begin
        r.den  = lclip_pkg::MagBits'(d);
        en_raw = -q_lo;
        ln_raw = q_hi;
      end else begin
        r.den  = lclip_pkg::MagBits'(-d);
        en_raw = -q_hi;
        ln_raw = q_lo;
      end
      den_s = signed'(lclip_pkg::RawBits'(r.den));
      // entering beyond t=1 or leaving before t=0 rejects
      r.rej = (en_raw > den_s) || (ln_raw < 0);
      r.en  = (en_raw < 0) ? '0 : lclip_pkg::MagBits'(en_raw);
      r.ln  = (ln_raw > den_s) ? r.den : lclip_pkg::MagBits'(ln_raw);
    end
    return r;
  endfunction

  function automatic lclip_pkg::acc_t mul_acc(input lclip_pkg::sacc_t a,
                                             input lclip_pkg::sacc_t b);
    return lclip_pkg::acc_t'(a * b);
  endfunction

  // Configuration registers
  lclip_pkg::screen_t width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lclip_pkg::ScreenWidthRst;
      height_q <= lclip_pkg::ScreenHeightRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lclip_pkg::RegScreenWidth:  width_q  <= cfg_data_i;
        lclip_pkg::RegScreenHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global pipeline advance: hold everything while the output is stalled
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Valid bits travel with the data
  logic s0_v_q, s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic [DivStages:0] dv_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      dv_v_q  <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q  <= in_valid_i;
      s1_v_q  <= s0_v_q;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      dv_v_q  <= {dv_v_q[DivStages-1:0], s4_v_q};
      out_v_q <= dv_v_q[DivStages];
    end
  end

  // Stage 0: input capture
  lclip_pkg::s0_t s0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q.x0 <= start_x_i;
      s0_q.y0 <= start_y_i;
      s0_q.x1 <= end_x_i;
      s0_q.y1 <= end_y_i;
    end
  end

  // Stage 1: deltas and per-axis ratios
  lclip_pkg::s1_t s1_d, s1_q;

  always_comb begin
    s1_d.x0  = s0_q.x0;
    s1_d.y0  = s0_q.y0;
    s1_d.dx  = lclip_pkg::delta_t'(s0_q.x1) - lclip_pkg::delta_t'(s0_q.x0);
    s1_d.dy  = lclip_pkg::delta_t'(s0_q.y1) - lclip_pkg::delta_t'(s0_q.y0);
    s1_d.ax  = axis_setup(s0_q.x0, s1_d.dx, width_q);
    s1_d.ay  = axis_setup(s0_q.y0, s1_d.dy, height_q);
    s1_d.rej = s1_d.ax.rej || s1_d.ay.rej;
  end

  always_ff @(posedge clk_i) begin
    if (adv) s1_q <= s1_d;
  end

  // Stage 2: cross products to order the two axes' ratios
  lclip_pkg::s2_t s2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q.x0  <= s1_q.x0;
      s2_q.y0  <= s1_q.y0;
      s2_q.dx  <= s1_q.dx;
      s2_q.dy  <= s1_q.dy;
      s2_q.ax  <= s1_q.ax;
      s2_q.ay  <= s1_q.ay;
      s2_q.rej <= s1_q.rej;
      s2_q.pex <= s1_q.ax.en * s1_q.ay.den;
      s2_q.pey <= s1_q.ay.en * s1_q.ax.den;
      s2_q.plx <= s1_q.ax.ln * s1_q.ay.den;
      s2_q.ply <= s1_q.ay.ln * s1_q.ax.den;
    end
  end

  // Stage 3: t0 = larger entering ratio, t1 = smaller leaving ratio
  lclip_pkg::s3_t s3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_q.x0  <= s2_q.x0;
      s3_q.y0  <= s2_q.y0;
      s3_q.dx  <= s2_q.dx;
      s3_q.dy  <= s2_q.dy;
      s3_q.rej <= s2_q.rej;
      if (s2_q.pex >= s2_q.pey) begin
        s3_q.n0 <= s2_q.ax.en;
        s3_q.d0 <= s2_q.ax.den;
      end else begin
        s3_q.n0 <= s2_q.ay.en;
        s3_q.d0 <= s2_q.ay.den;
      end
      if (s2_q.plx <= s2_q.ply) begin
        s3_q.n1 <= s2_q.ax.ln;
        s3_q.d1 <= s2_q.ax.den;
      end else begin
        s3_q.n1 <= s2_q.ay.ln;
        s3_q.d1 <= s2_q.ay.den;
      end
    end
  end

  // Stage 4: t0 vs t1 products and point numerator terms
  lclip_pkg::s4_t s4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q.c01   <= s3_q.n0 * s3_q.d1;
      s4_q.c10   <= s3_q.n1 * s3_q.d0;
      s4_q.ta[0] <= mul_acc(lclip_pkg::sacc_t'(s3_q.x0), lclip_pkg::sacc_t'(s3_q.d0));
      s4_q.tb[0] <= mul_acc(lclip_pkg::sacc_t'(s3_q.dx), lclip_pkg::sacc_t'(s3_q.n0));
      s4_q.ta[1] <= mul_acc(lclip_pkg::sacc_t'(s3_q.y0), lclip_pkg::sacc_t'(s3_q.d0));
      s4_q.tb[1] <= mul_acc(lclip_pkg::sacc_t'(s3_q.dy), lclip_pkg::sacc_t'(s3_q.n0));
      s4_q.ta[2] <= mul_acc(lclip_pkg::sacc_t'(s3_q.x0), lclip_pkg::sacc_t'(s3_q.d1));
      s4_q.tb[2] <= mul_acc(lclip_pkg::sacc_t'(s3_q.dx), lclip_pkg::sacc_t'(s3_q.n1));
      s4_q.ta[3] <= mul_acc(lclip_pkg::sacc_t'(s3_q.y0), lclip_pkg::sacc_t'(s3_q.d1));
      s4_q.tb[3] <= mul_acc(lclip_pkg::sacc_t'(s3_q.dy), lclip_pkg::sacc_t'(s3_q.n1));
      s4_q.d0    <= s3_q.d0;
      s4_q.d1    <= s3_q.d1;
      s4_q.rej   <= s3_q.rej;
    end
  end

  // Stage 5: final reject and point numerators (divider input)
  lclip_pkg::div_t dv_q [DivStages+1];
  lclip_pkg::div_t dv_d [DivStages+1];

  always_comb begin
    dv_d[0].d0  = s4_q.d0;
    dv_d[0].d1  = s4_q.d1;
    dv_d[0].rej = s4_q.rej || (s4_q.c01 > s4_q.c10);
    dv_d[0].quo = '0;
    for (int i = 0; i < NumPts; i++) begin
      dv_d[0].rem[i] = s4_q.ta[i] + s4_q.tb[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) dv_q[0] <= dv_d[0];
  end

  // Restoring divider: quotient bits from the top, DivBitsPerStage of them per stage
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    localparam int TopBit = lclip_pkg::QuoBits - 1 - lclip_pkg::DivBitsPerStage * k;

    always_comb begin
      lclip_pkg::acc_t den;
      lclip_pkg::acc_t sub;
      dv_d[k+1] = dv_q[k];
      for (int i = 0; i < NumPts; i++) begin
        den = (i < 2) ? lclip_pkg::AccBits'(dv_q[k].d0) : lclip_pkg::AccBits'(dv_q[k].d1);
        for (int j = 0; j < lclip_pkg::DivBitsPerStage; j++) begin
          if (TopBit - j >= 0) begin
            sub = den << (TopBit - j);
            if (dv_d[k+1].rem[i] >= sub) begin
              dv_d[k+1].rem[i]              = dv_d[k+1].rem[i] - sub;
              dv_d[k+1].quo[i][TopBit - j] = 1'b1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) dv_q[k+1] <= dv_d[k+1];
    end
  end

  // Output register: zero coordinates on reject
  logic                vis_q;
  lclip_pkg::quo_t [NumPts-1:0] pts_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= !dv_q[DivStages].rej;
      pts_q <= dv_q[DivStages].rej ? '0 : dv_q[DivStages].quo;
    end
  end

  assign out_valid_o   = out_v_q;
  assign visible_o     = vis_q;
  assign out_start_x_o = pts_q[0];
  assign out_start_y_o = pts_q[1];
  assign out_end_x_o   = pts_q[2];
  assign out_end_y_o   = pts_q[3];

  // Checks
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !visible_o) |->
      (out_start_x_o == '0 && out_start_y_o == '0 && out_end_x_o == '0 && out_end_y_o == '0))
    else $error("rejected segment with nonzero coordinates");

  a_x_in_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && visible_o) |-> (out_start_x_o <= width_q && out_end_x_o <= width_q))
    else $error("clipped x outside rectangle");

  a_y_in_rect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && visible_o) |-> (out_start_y_o <= height_q && out_end_y_o <= height_q))
    else $error("clipped y outside rectangle");

endmodule
